FILE: rtl/opp_pkg.sv
// Onset peak picker shared types and constants.
// No dependencies.
package opp_pkg;

  localparam int FLUX_W = 32;
  localparam int SUM_W  = 48;

  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_UPPER    = 3'd1;
  localparam logic [2:0] REG_LOWER    = 3'd2;
  localparam logic [2:0] REG_HOLDOFF  = 3'd3;
  localparam logic [2:0] REG_DECAY    = 3'd4;
  localparam logic [2:0] REG_MASKLEN  = 3'd5;

  localparam logic signed [31:0] UPPER_RESET = 32'sd19661;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch input word, do masking/hold-off bookkeeping
    logic decay;      // one decay multiply
    logic hist_rd;    // read history entry
    logic hist_upd;   // update sum, write history, start divide
    logic div_step;   // one divider step
    logic scale;      // form thresholds
    logic pick;       // peak picking, load output
  } opp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic decay_more;
    logic positive;
    logic div_done;
  } opp_sts_t;

endpackage

FILE: rtl/opp_if.sv
// Valid/ready stream interface for the onset peak picker.
// Depends on nothing; payload width is a parameter.
interface opp_if #(parameter int W = 32) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/opp_ctrl.sv
// Onset peak picker controller: sequences one frame through the datapath.
// Depends on opp_pkg.
module opp_ctrl
  import opp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  opp_sts_t sts,
  output opp_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DECAY, S_RD, S_UPD, S_DIV, S_SCALE, S_PICK} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    cmd = '0;
    cmd.load     = in_valid && in_ready;
    cmd.decay    = (state == S_DECAY) && sts.decay_more;
    cmd.hist_rd  = (state == S_RD);
    cmd.hist_upd = (state == S_UPD);
    cmd.div_step = (state == S_DIV) && !sts.div_done;
    cmd.scale    = (state == S_SCALE);
    cmd.pick     = (state == S_PICK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PICK) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:  if (cmd.load) state <= S_DECAY;
        S_DECAY: if (!sts.decay_more) state <= sts.positive ? S_RD : S_PICK;
        S_RD:    state <= S_UPD;
        S_UPD:   state <= S_DIV;
        S_DIV:   if (sts.div_done) state <= S_SCALE;
        S_SCALE: state <= S_PICK;
        S_PICK:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/opp_dp.sv
// Onset peak picker datapath: masking, hold-off, history mean, peak picking.
// Depends on opp_pkg.
module opp_dp
  import opp_pkg::*;
#(
  parameter int HISTORY_LEN = 100
) (
  input  logic                     clk,
  input  logic                     rst,
  input  opp_cmd_t                 cmd,
  output opp_sts_t                 sts,
  input  logic signed [31:0]       flux_in,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_idx,
  input  logic [15:0]              cfg_data,
  output logic                     onset,
  output logic signed [31:0]       masked_flux,
  output logic signed [31:0]       upper_level
);

  localparam int IW = $clog2(HISTORY_LEN);
  localparam int CW = $clog2(HISTORY_LEN + 1);
  localparam int SW = SUM_W;
  localparam logic [CW-1:0] HLEN = CW'(HISTORY_LEN);
  localparam logic [IW-1:0] HLAST = IW'(HISTORY_LEN - 1);

  // configuration registers
  logic [7:0]  debounce_limit, holdoff_limit, mask_length;
  logic [15:0] upper_scale, lower_scale, mask_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit <= 8'd5;
      upper_scale    <= 16'd512;
      lower_scale    <= 16'd512;
      holdoff_limit  <= 8'd15;
      mask_decay     <= 16'd45875;
      mask_length    <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEBOUNCE: debounce_limit <= cfg_data[7:0];
        REG_UPPER:    upper_scale    <= cfg_data;
        REG_LOWER:    lower_scale    <= cfg_data;
        REG_HOLDOFF:  holdoff_limit  <= cfg_data[7:0];
        REG_DECAY:    mask_decay     <= cfg_data;
        REG_MASKLEN:  mask_length    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic armed, holdoff_active, mask_active, first_fill;
  logic [7:0] debounce_count, holdoff_count, mask_count, decay_left;
  logic signed [31:0] peak_level, upper_threshold, lower_threshold, f;
  logic [IW-1:0] history_index;
  logic [SW-1:0] history_sum;
  logic [31:0] history [HISTORY_LEN];
  logic [31:0] old_entry;

  // divider
  logic [SW-1:0] quot, rem;
  logic [CW-1:0] divisor;
  logic [5:0]    div_cnt;
  logic [SW:0]   trial;
  logic [SW-1:0] mean;

  logic neg;
  logic [31:0] mag;
  logic [47:0] prod;
  assign neg  = f[31];
  assign mag  = neg ? (32'd0 - f) : f;
  assign prod = mag * mask_decay;

  assign sts.decay_more = (decay_left != 8'd0);
  assign sts.positive   = (f > 0);
  assign sts.div_done   = (div_cnt == 6'd0);

  assign trial = {rem, quot[SW-1]} - {{(SW+1-CW){1'b0}}, divisor};

  logic [63:0] up_p, lo_p;
  assign up_p = mean * upper_scale;
  assign lo_p = mean * lower_scale;

  function automatic logic signed [31:0] sat(input logic [63:0] p);
    logic [55:0] s;
    s = p[63:8];
    sat = (s > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : s[31:0];
  endfunction

  logic [7:0] mask_diff;
  assign mask_diff = mask_length - mask_count;

  logic onset_hit;
  assign onset_hit = armed && !(f > peak_level) && !holdoff_active &&
                     (debounce_count > debounce_limit || f < lower_threshold);

  always_ff @(posedge clk) begin
    if (cmd.hist_upd) history[history_index] <= f;
    if (cmd.hist_rd) old_entry <= history[history_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0; holdoff_active <= 1'b0; mask_active <= 1'b0; first_fill <= 1'b1;
      debounce_count <= '0; holdoff_count <= '0; mask_count <= '0; decay_left <= '0;
      upper_threshold <= UPPER_RESET; lower_threshold <= '0;
      history_index <= '0; history_sum <= '0; div_cnt <= '0;
      onset <= 1'b0;
    end else begin
      if (cmd.load) begin
        f <= flux_in;
        decay_left <= (mask_active && (mask_count < mask_length)) ? mask_diff : 8'd0;
        if (mask_active) begin
          if (mask_count == mask_length) begin
            mask_active <= 1'b0;
            mask_count  <= 8'd1;
          end else begin
            mask_count <= mask_count + 8'd1;
          end
        end
        if (holdoff_active) begin
          if (holdoff_count > holdoff_limit) begin
            holdoff_active <= 1'b0;
            holdoff_count  <= '0;
          end else holdoff_count <= holdoff_count + 8'd1;
        end
      end
      if (cmd.decay) begin
        f <= neg ? (32'd0 - prod[47:16]) : prod[47:16];
        decay_left <= decay_left - 8'd1;
      end
      if (cmd.hist_upd) begin
        if (first_fill) begin
          history_sum <= history_sum + SW'(f);
          quot <= history_sum + SW'(f);
          divisor <= CW'(history_index) + CW'(1);
        end else begin
          history_sum <= history_sum - SW'(old_entry) + SW'(f);
          quot <= history_sum - SW'(old_entry) + SW'(f);
          divisor <= HLEN;
        end
        rem <= '0;
        div_cnt <= 6'(SW);
        if (history_index == HLAST) begin
          history_index <= '0;
          first_fill <= 1'b0;
        end else history_index <= history_index + IW'(1);
      end
      if (cmd.div_step) begin
        // restoring divide, one quotient bit a cycle
        if (!trial[SW]) begin
          rem  <= trial[SW-1:0];
          quot <= {quot[SW-2:0], 1'b1};
        end else begin
          rem  <= {rem[SW-2:0], quot[SW-1]};
          quot <= {quot[SW-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 6'd1;
      end
      if (sts.div_done) mean <= quot;
      if (cmd.scale) begin
        upper_threshold <= sat(up_p);
        lower_threshold <= sat(lo_p);
      end
      if (cmd.pick) begin
        onset <= onset_hit;
        if (!armed) begin
          if (f > upper_threshold && !holdoff_active) begin
            armed <= 1'b1; debounce_count <= '0; peak_level <= f;
          end
        end else if (f > peak_level) begin
          if (!holdoff_active) begin
            debounce_count <= '0; peak_level <= f;
          end
        end else if (debounce_count > debounce_limit || f < lower_threshold) begin
          if (!holdoff_active) begin
            debounce_count <= '0; armed <= 1'b0;
            holdoff_active <= 1'b1; mask_active <= 1'b1;
          end
        end else debounce_count <= debounce_count + 8'd1;
        masked_flux <= f;
      end
    end
  end

  assign upper_level = upper_threshold;

endmodule

FILE: rtl/onset_peak_picker_core.sv
// Onset peak picker top level: controller plus datapath.
// Depends on opp_pkg, opp_if, opp_ctrl, opp_dp.
// Per word: accept, then the frame's n mask multiplies; positive flux then takes a history
// read, sum update, 48-step restoring divide and threshold scaling; then peak picking.
// One word at a time: a new word is taken only in idle and not while a result is stalled.
// Reset (rst, synchronous) restores register defaults and detector state; no clearing pass.
module onset_peak_picker_core
  import opp_pkg::*;
#(
  parameter int HISTORY_LEN = 100
) (
  input logic clk,
  input logic rst,
  opp_if.sink   in_ch,
  opp_if.source out_ch,
  opp_if.sink   cfg_ch
);

  opp_cmd_t cmd;
  opp_sts_t sts;
  logic onset;
  logic signed [31:0] masked_flux, upper_level;

  // config writes always taken
  assign cfg_ch.ready = 1'b1;

  opp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  opp_dp #(.HISTORY_LEN(HISTORY_LEN)) u_dp (
    .clk, .rst, .cmd, .sts,
    .flux_in(in_ch.data[31:0]),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.data[18:16]), .cfg_data(cfg_ch.data[15:0]),
    .onset, .masked_flux, .upper_level
  );

  // output word: {onset, masked_flux, upper_level}
  assign out_ch.data = {onset, masked_flux, upper_level};

endmodule
